/* hdl/cosu_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the cosine similarity unit.
// Used by the front, queue and back modules; depends on nothing.
package cosu_pkg;

  localparam int SUM_W     = 48;
  localparam int PROD_W    = 2 * SUM_W;
  localparam int FRAC_W    = 14;
  localparam int R_W       = FRAC_W + 1;
  localparam int SIM_W     = 16;
  localparam int WIDE_W    = 2 * PROD_W - 62;
  localparam int US_SHIFT  = R_W + 1;
  localparam int RHS_SHIFT = 2 * FRAC_W + 2;
  localparam int MUL_CNT_W = $clog2(SUM_W);

  typedef struct packed {
    logic [SUM_W-1:0] dot;
    logic [SUM_W-1:0] first_sq;
    logic [SUM_W-1:0] second_sq;
    logic             overflow;
  } sums_t;

  typedef struct packed {
    logic [SIM_W-1:0] similarity;
    logic             zero_norm;
    logic             overflow;
  } result_t;

endpackage

/* hdl/cosu_front.sv */
`timescale 1ns / 1ps
// Front end: multiplies each element pair and keeps the three running sums.
// On the last pair it pushes the finished sums into the queue. Uses cosu_pkg.
module cosu_front import cosu_pkg::*; #(
  parameter int MAX_LEN   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ELEM_BITS-1:0] a_value,
  input  logic [ELEM_BITS-1:0] b_value,
  input  logic                 last,
  output logic                 q_valid,
  input  logic                 q_ready,
  output sums_t                q_entry
);

  localparam int PW    = 2 * ELEM_BITS;
  localparam int EXT_W = SUM_W + PW;
  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic signed [PW-1:0]    ab_prod, aa_prod, bb_prod;
  logic signed [EXT_W-1:0] ab_ext, aa_ext, bb_ext;

  logic             s1_valid;
  logic             s1_last;
  logic [SUM_W-1:0] s1_ab, s1_aa, s1_bb;

  logic [SUM_W-1:0] dot_sum, first_square_sum, second_square_sum;
  logic [SUM_W-1:0] dot_sum_next, first_square_sum_next, second_square_sum_next;
  logic [CNT_W-1:0] element_count;
  logic             length_exceeded, length_exceeded_next;
  logic             room;
  logic             advance;

  assign ab_prod = $signed(a_value) * $signed(b_value);
  assign aa_prod = $signed(a_value) * $signed(a_value);
  assign bb_prod = $signed(b_value) * $signed(b_value);
  assign ab_ext  = EXT_W'(ab_prod);
  assign aa_ext  = EXT_W'(aa_prod);
  assign bb_ext  = EXT_W'(bb_prod);

  assign room    = element_count < CNT_W'(MAX_LEN);
  assign advance = s1_valid && (!s1_last || q_ready);
  assign in_ready = !s1_valid || advance;

  always_comb begin
    dot_sum_next           = dot_sum;
    first_square_sum_next  = first_square_sum;
    second_square_sum_next = second_square_sum;
    length_exceeded_next   = length_exceeded;
    if (room) begin
      dot_sum_next           = dot_sum + s1_ab;
      first_square_sum_next  = first_square_sum + s1_aa;
      second_square_sum_next = second_square_sum + s1_bb;
    end else begin
      length_exceeded_next = 1'b1;
    end
  end

  assign q_valid            = s1_valid && s1_last;
  assign q_entry.dot        = dot_sum_next;
  assign q_entry.first_sq   = first_square_sum_next;
  assign q_entry.second_sq  = second_square_sum_next;
  assign q_entry.overflow   = length_exceeded_next;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_last <= last;
      s1_ab   <= ab_ext[SUM_W-1:0];
      s1_aa   <= aa_ext[SUM_W-1:0];
      s1_bb   <= bb_ext[SUM_W-1:0];
    end
    if (rst) begin
      s1_valid          <= 1'b0;
      dot_sum           <= '0;
      first_square_sum  <= '0;
      second_square_sum <= '0;
      element_count     <= '0;
      length_exceeded   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        if (s1_last) begin
          dot_sum           <= '0;
          first_square_sum  <= '0;
          second_square_sum <= '0;
          element_count     <= '0;
          length_exceeded   <= 1'b0;
        end else begin
          dot_sum           <= dot_sum_next;
          first_square_sum  <= first_square_sum_next;
          second_square_sum <= second_square_sum_next;
          length_exceeded   <= length_exceeded_next;
          if (room) begin
            element_count <= element_count + CNT_W'(1);
          end
        end
      end
    end
  end

endmodule

/* hdl/cosu_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of finished sums between the front and the back end.
// Uses cosu_pkg for the entry type.
module cosu_queue import cosu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  sums_t in_entry,
  output logic  out_valid,
  input  logic  out_ready,
  output sums_t out_entry
);

  sums_t      slots [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       push, pop;

  assign in_ready  = fill != 2'd2;
  assign out_valid = fill != 2'd0;
  assign out_entry = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= in_entry;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (pop) begin
        rp <= !rp;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* hdl/cosu_back.sv */
`timescale 1ns / 1ps
// Back end: squares the dot and the norm product by shift and add, then
// finds Q1.14 result bitwise by incremental square compare. Uses cosu_pkg.
module cosu_back import cosu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  output logic    q_ready,
  input  sums_t   q_entry,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  typedef enum logic [1:0] {IDLE, MUL, SRCH, DONE} state_t;

  state_t state;

  logic [MUL_CNT_W-1:0] cnt;
  logic [3:0]           k;
  logic                 phase;
  logic                 neg, zero, ovf;
  logic [R_W-1:0]       r;

  logic [SUM_W-1:0]  aa_sh, m_sh;
  logic [PROD_W-1:0] bb_sh, m2_sh, p_acc, d_acc;
  logic [PROD_W-1:0] p_add, d_add;
  logic [SUM_W-1:0]  mag;

  logic signed [WIDE_W-1:0] t, us, ps, rr, cand;
  logic signed [WIDE_W-1:0] wide_p, wide_d, us_upd;
  logic                     cand_ok;

  assign q_ready = state == IDLE;
  assign mag     = q_entry.dot[SUM_W-1] ? SUM_W'(0) - q_entry.dot : q_entry.dot;
  assign p_add   = aa_sh[0] ? p_acc + bb_sh : p_acc;
  assign d_add   = m_sh[0] ? d_acc + m2_sh : d_acc;
  assign wide_p  = WIDE_W'(p_add);
  assign wide_d  = WIDE_W'(d_add);
  assign cand_ok = !r[R_W-1] && (cand <= rr);
  assign us_upd  = cand_ok ? us + (ps <<< 1) : us;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            neg   <= q_entry.dot[SUM_W-1];
            ovf   <= q_entry.overflow;
            zero  <= (q_entry.first_sq == '0) || (q_entry.second_sq == '0);
            aa_sh <= q_entry.first_sq;
            bb_sh <= PROD_W'(q_entry.second_sq);
            m_sh  <= mag;
            m2_sh <= PROD_W'(mag);
            p_acc <= '0;
            d_acc <= '0;
            cnt   <= '0;
            r     <= '0;
            k     <= 4'(R_W - 1);
            phase <= 1'b0;
            if ((q_entry.first_sq == '0) || (q_entry.second_sq == '0)) begin
              state <= DONE;
            end else begin
              state <= MUL;
            end
          end
        end
        MUL: begin
          p_acc <= p_add;
          d_acc <= d_add;
          aa_sh <= aa_sh >> 1;
          m_sh  <= m_sh >> 1;
          bb_sh <= bb_sh << 1;
          m2_sh <= m2_sh << 1;
          cnt   <= cnt + MUL_CNT_W'(1);
          if (cnt == MUL_CNT_W'(SUM_W - 1)) begin
            t     <= wide_p;
            us    <= WIDE_W'(0) - (wide_p <<< US_SHIFT);
            ps    <= wide_p <<< RHS_SHIFT;
            rr    <= wide_d <<< RHS_SHIFT;
            state <= SRCH;
          end
        end
        SRCH: begin
          if (!phase) begin
            cand  <= t + us + ps;
            phase <= 1'b1;
          end else begin
            if (cand_ok) begin
              t    <= cand;
              r[k] <= 1'b1;
            end
            us    <= us_upd >>> 1;
            ps    <= ps >>> 2;
            phase <= 1'b0;
            if (k == 4'd0) begin
              state <= DONE;
            end else begin
              k <= k - 4'd1;
            end
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_result.zero_norm  <= zero;
            out_result.overflow   <= ovf;
            if (zero) begin
              out_result.similarity <= '0;
            end else if (neg) begin
              out_result.similarity <= SIM_W'(0) - SIM_W'(r);
            end else begin
              out_result.similarity <= SIM_W'(r);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* hdl/cosine_similarity_unit.sv */
`timescale 1ns / 1ps
// Cosine similarity unit: accepts one element pair per cycle into three running sums,
// except while a registered last pair waits for room in the queue. After the last pair
// of a vector the back end forms the norm products by shift and add, then searches the
// result bit by bit; when a norm is zero it skips both. The back end takes a new vector
// only once it is through with the last one; two finished vectors may wait between.
// Synchronous active-high reset clears the sums, the queue and the output valid flag.
module cosine_similarity_unit import cosu_pkg::*; #(
  parameter int MAX_LEN   = 1024,
  parameter int ELEM_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((2 * ELEM_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata, // a_value, b_value
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [SIM_W-1:0]                       m_axis_tdata, // similarity
  output logic [1:0]                             m_axis_tuser  // zero_norm, overflow
);

  sums_t   front_entry, back_entry;
  result_t result;
  logic    front_valid, front_ready, back_valid, back_ready;

  cosu_front #(
    .MAX_LEN   (MAX_LEN),
    .ELEM_BITS (ELEM_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .a_value  (s_axis_tdata[ELEM_BITS-1:0]),
    .b_value  (s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
    .last     (s_axis_tlast),
    .q_valid  (front_valid),
    .q_ready  (front_ready),
    .q_entry  (front_entry)
  );

  cosu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_entry  (front_entry),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_entry (back_entry)
  );

  cosu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (back_valid),
    .q_ready    (back_ready),
    .q_entry    (back_entry),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata    = result.similarity;
  assign m_axis_tuser[0] = result.zero_norm;
  assign m_axis_tuser[1] = result.overflow;

endmodule
